FILE: rtl/crq_pkg.sv
// Shared types and constants for the coalescing request queue.
// No dependencies; compiled first.
package crq_pkg;

  localparam int FIELD_W = 16;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CLR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED       = 3'd0,
    ST_OVERWRITTEN = 3'd1,
    ST_FULL        = 3'd2,
    ST_POPPED      = 3'd3,
    ST_EMPTY       = 3'd4,
    ST_DROPPED     = 3'd5,
    ST_CLEARED     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_ALLOC_LINK,
    S_DEQ,
    S_RESP
  } state_t;

endpackage

FILE: rtl/crq_in_if.sv
// Request channel of the coalescing request queue: valid/ready plus one request.
// Depends on crq_pkg.
interface crq_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [crq_pkg::FIELD_W-1:0]  requester_id;
  logic [crq_pkg::FIELD_W-1:0]  from_anchor;
  logic [crq_pkg::FIELD_W-1:0]  to_anchor;
  logic                         request_valid;
  logic                         priority_request;
  logic                         head_owner_is_npc;
  logic                         head_owner_idle;

  modport source (
    output valid, opcode, requester_id, from_anchor, to_anchor, request_valid,
           priority_request, head_owner_is_npc, head_owner_idle,
    input  ready
  );
  modport sink (
    input  valid, opcode, requester_id, from_anchor, to_anchor, request_valid,
           priority_request, head_owner_is_npc, head_owner_idle,
    output ready
  );
endinterface

FILE: rtl/crq_out_if.sv
// Result channel of the coalescing request queue: valid/ready plus one result.
// Depends on crq_pkg; CNT_W follows the queue depth.
interface crq_out_if #(parameter int CNT_W = 6);
  logic                         valid;
  logic                         ready;
  crq_pkg::status_t             status;
  logic [crq_pkg::FIELD_W-1:0]  out_requester_id;
  logic [crq_pkg::FIELD_W-1:0]  out_from_anchor;
  logic [crq_pkg::FIELD_W-1:0]  out_to_anchor;
  logic                         out_request_valid;
  logic [CNT_W-1:0]             queue_count;

  modport source (
    output valid, status, out_requester_id, out_from_anchor, out_to_anchor,
           out_request_valid, queue_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_requester_id, out_from_anchor, out_to_anchor,
           out_request_valid, queue_count,
    output ready
  );
endinterface

FILE: rtl/coalescing_request_queue.sv
// The enqueue id search walks the linked list, one entry per cycle of the payload memory.
// Throughput: one item at a time; the next request is taken once the result is
//   registered, while that result may still wait on the output.
// Reset (synchronous): empties the queue and allocation counters;
//   no clearing pass over the memories.
module coalescing_request_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 16
) (
  input  logic      clk,
  input  logic      rst,
  crq_in_if.sink    req,
  crq_out_if.source res
);
  import crq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W  = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
  localparam int PAY_W = ID_W + 2 * FIELD_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

  // memories
  logic [PAY_W-1:0] pay_mem  [QUEUE_DEPTH];
  logic [IDX_W-1:0] link_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0] stk_mem  [QUEUE_DEPTH];   // recycled entries
  logic [PAY_W-1:0] pay_rd;
  logic [IDX_W-1:0] link_rd;
  logic [IDX_W-1:0] stk_rd;

  state_t state, state_next;

  // control
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] fresh;   // entries fresh..DEPTH-1 never used since clear
  logic [CNT_W-1:0] sp;
  logic             out_valid;

  // request and work registers
  logic [ID_W-1:0]    id_r;
  logic [FIELD_W-1:0] from_r;
  logic [FIELD_W-1:0] to_r;
  logic               val_r;
  logic               prio_r;
  logic               drop_r;
  logic [IDX_W-1:0]   cur;
  logic [CNT_W-1:0]   walk_n;
  logic [IDX_W-1:0]   ne_r;
  status_t            status_r;
  logic [PAY_W-1:0]   res_pay;

  // output registers
  status_t          o_status;
  logic [PAY_W-1:0] o_pay;
  logic [CNT_W-1:0] o_count;

  // memory controls
  logic [IDX_W-1:0] rd_addr;
  logic             pay_we;
  logic [IDX_W-1:0] pay_waddr;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [IDX_W-1:0] link_wdata;
  logic             stk_we;
  logic [CNT_W-1:0] sp_dec;

  logic             accept;
  op_t              op;
  logic             walk_hit;
  logic             walk_last;
  logic             prio_ins;
  logic             out_free;
  logic [IDX_W-1:0] ne;
  logic [PAY_W-1:0] pay_wd;

  assign accept    = req.valid && req.ready;
  assign op        = op_t'(req.opcode);
  assign walk_hit  = (pay_rd[PAY_W-1 -: ID_W] == id_r);
  assign walk_last = ((walk_n + ONE_C) == count);
  assign prio_ins  = prio_r && (count >= TWO_C);
  assign out_free  = !out_valid || res.ready;
  assign sp_dec    = sp - ONE_C;
  assign ne        = (fresh != DEPTH_C) ? fresh[IDX_W-1:0] : stk_rd;
  assign pay_wd    = {id_r, from_r, to_r, val_r};

  assign req.ready             = (state == S_IDLE);
  assign res.valid             = out_valid;
  assign res.status            = o_status;
  assign res.out_requester_id  = FIELD_W'(o_pay[PAY_W-1 -: ID_W]);
  assign res.out_from_anchor   = o_pay[2*FIELD_W : FIELD_W+1];
  assign res.out_to_anchor     = o_pay[FIELD_W:1];
  assign res.out_request_valid = o_pay[0];
  assign res.queue_count       = o_count;

  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[pay_waddr] <= pay_wd;
    pay_rd <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rd <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[sp[IDX_W-1:0]] <= head;
    stk_rd <= stk_mem[sp_dec[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = head;
    pay_we     = 1'b0;
    pay_waddr  = cur;
    link_we    = 1'b0;
    link_waddr = tail;
    link_wdata = ne;
    stk_we     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_ENQ:  state_next = (count == '0) ? S_ALLOC_RD : S_WALK;
            OP_DEQ:  state_next = (count == '0) ? S_RESP : S_DEQ;
            default: state_next = S_RESP;   // clear; the spare code clears too
          endcase
        end
      end
      S_WALK: begin
        if (walk_hit && walk_n != '0) begin
          pay_we     = 1'b1;
          state_next = S_RESP;
        end else if (walk_hit || walk_last) begin
          // a match at the head may be in service: take a new entry
          state_next = S_ALLOC_RD;
        end else begin
          rd_addr = link_rd;
        end
      end
      S_ALLOC_RD: begin
        state_next = (count == DEPTH_C) ? S_RESP : S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        pay_we    = 1'b1;
        pay_waddr = ne;
        if (count == '0) begin
          state_next = S_RESP;
        end else if (prio_ins) begin
          link_we    = 1'b1;
          link_waddr = ne;
          link_wdata = link_rd;
          state_next = S_ALLOC_LINK;
        end else begin
          link_we    = 1'b1;
          state_next = S_RESP;
        end
      end
      S_ALLOC_LINK: begin
        link_we    = 1'b1;
        link_waddr = head;
        link_wdata = ne_r;
        state_next = S_RESP;
      end
      S_DEQ: begin
        stk_we     = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      head      <= '0;
      tail      <= '0;
      fresh     <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && op != OP_ENQ && op != OP_DEQ) begin
            count <= '0;
            head  <= '0;
            tail  <= '0;
            fresh <= '0;
            sp    <= '0;
          end
        end
        S_ALLOC_WR: begin
          count <= count + ONE_C;
          if (fresh != DEPTH_C) begin
            fresh <= fresh + ONE_C;
          end else begin
            sp <= sp_dec;
          end
          if (count == '0) begin
            head <= ne;
            tail <= ne;
          end else if (!prio_ins) begin
            tail <= ne;
          end
        end
        S_DEQ: begin
          sp    <= sp + ONE_C;
          count <= count - ONE_C;
          if (count == ONE_C) begin
            head <= '0;
            tail <= '0;
          end else begin
            head <= link_rd;
          end
        end
        default: ;
      endcase
    end
  end

  // request capture, result building, output register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          id_r    <= req.requester_id[ID_W-1:0];
          from_r  <= req.from_anchor;
          to_r    <= req.to_anchor;
          val_r   <= req.request_valid;
          prio_r  <= req.priority_request;
          drop_r  <= req.head_owner_is_npc && req.head_owner_idle;
          cur     <= head;
          walk_n  <= '0;
          res_pay <= '0;
          if (op == OP_DEQ) begin
            status_r <= ST_EMPTY;
          end else begin
            status_r <= ST_CLEARED;
          end
        end
      end
      S_WALK: begin
        if (walk_hit && walk_n != '0) begin
          status_r <= ST_OVERWRITTEN;
        end else if (!walk_hit && !walk_last) begin
          cur    <= link_rd;
          walk_n <= walk_n + ONE_C;
        end
      end
      S_ALLOC_RD: status_r <= ST_FULL;
      S_ALLOC_WR: begin
        status_r <= ST_ADDED;
        ne_r     <= ne;
      end
      S_DEQ: begin
        if (drop_r) begin
          status_r <= ST_DROPPED;
        end else begin
          status_r <= ST_POPPED;
          res_pay  <= pay_rd;
        end
      end
      S_RESP: begin
        if (out_free) begin
          o_status <= status_r;
          o_pay    <= res_pay;
          o_count  <= count;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/crq_check.sv
// Port-level checks for the coalescing request queue, bound to the top level.
// Depends on crq_pkg and crq_out_if.
module crq_check #(
  parameter int QUEUE_DEPTH = 32
) (
  input logic       clk,
  input logic       rst,
  crq_out_if.source res
);
  import crq_pkg::*;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.queue_count <= QUEUE_DEPTH))
    else $error("queue_count above depth");

  a_zero_after_clear: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == ST_CLEARED || res.status == ST_EMPTY))
      |-> (res.queue_count == '0))
    else $error("clear or empty with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_FULL) |-> (res.queue_count == QUEUE_DEPTH))
    else $error("full reported below depth");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != ST_POPPED)
      |-> (res.out_requester_id == '0 && res.out_from_anchor == '0 &&
           res.out_to_anchor == '0 && !res.out_request_valid))
    else $error("payload on non-pop result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.status) &&
                                   $stable(res.queue_count)))
    else $error("stalled result changed");

endmodule

bind coalescing_request_queue crq_check #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_crq_check (
  .clk (clk),
  .rst (rst),
  .res (res)
);

FILE: bench/tb_coalescing_request_queue.sv
`timescale 1ns / 1ps
// Self-checking bench for coalescing_request_queue: random gaps on both channels,
// results checked against an in-bench model of the linked request list.
// Depends on crq_pkg, crq_in_if, crq_out_if and the queue RTL.
module tb_coalescing_request_queue;
  import crq_pkg::*;

  localparam int DEPTH = 32;
  localparam int ID_W = 16;
  localparam int CNT_W = 6;
  localparam logic [1:0] OP_RSVD = 2'd3;   // reserved opcode, behaves as clear
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = DEPTH + 8;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [15:0]     src;
    logic [15:0]     dst;
    logic            vld;
  } request_t;

  typedef struct packed {
    status_t         status;
    logic [15:0]     id;
    logic [15:0]     src;
    logic [15:0]     dst;
    logic            vld;
    logic [CNT_W-1:0] count;
  } reply_t;

  logic clk = 1'b0;
  logic rst;

  crq_in_if req_if ();
  crq_out_if #(.CNT_W(CNT_W)) rsp_if ();

  coalescing_request_queue #(
    .QUEUE_DEPTH(DEPTH),
    .ID_BITS(ID_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model of the queue
  request_t slot_req [DEPTH];
  int       slot_next [DEPTH];
  bit       slot_free [DEPTH];
  int       head_slot;
  int       tail_slot;
  int       live_count;

  reply_t   replies_due [$];
  int       error_count = 0;
  int       quiet_cycles = 0;
  int       stall_left = 0;
  int       hold_off_cycles = 0;
  bit       sender_steady = 1'b0;
  bit       receiver_steady = 1'b0;

  function automatic void empty_queue_model();
    for (int i = 0; i < DEPTH; i++) slot_free[i] = 1'b1;
    head_slot = 0;
    tail_slot = 0;
    live_count = 0;
  endfunction

  function automatic reply_t advance_queue_model(logic [1:0] op, request_t rq,
                                                 logic prio, logic npc, logic idle);
    reply_t r;
    int hit;
    int cur;
    int slot;
    r = '0;
    case (op)
      OP_ENQ: begin
        hit = -1;
        cur = head_slot;
        for (int n = 0; n < live_count; n++) begin
          if (hit < 0 && slot_req[cur].id == rq.id) hit = cur;
          cur = slot_next[cur];
        end
        if (hit >= 0 && hit != head_slot) begin
          slot_req[hit] = rq;
          r.status = ST_OVERWRITTEN;
        end else begin
          slot = -1;
          for (int i = DEPTH - 1; i >= 0; i--) if (slot_free[i]) slot = i;
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_free[slot] = 1'b0;
            slot_req[slot] = rq;
            if (live_count == 0) begin
              head_slot = slot;
              tail_slot = slot;
            end else if (prio && live_count >= 2) begin
              slot_next[slot] = slot_next[head_slot];
              slot_next[head_slot] = slot;
            end else begin
              slot_next[tail_slot] = slot;
              tail_slot = slot;
            end
            live_count++;
            r.status = ST_ADDED;
          end
        end
      end
      OP_DEQ: begin
        if (live_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (npc && idle) begin
            r.status = ST_DROPPED;
          end else begin
            r.status = ST_POPPED;
            r.id = slot_req[head_slot].id;
            r.src = slot_req[head_slot].src;
            r.dst = slot_req[head_slot].dst;
            r.vld = slot_req[head_slot].vld;
          end
          slot_free[head_slot] = 1'b1;
          live_count--;
          if (live_count == 0) begin
            head_slot = 0;
            tail_slot = 0;
          end else begin
            head_slot = slot_next[head_slot];
          end
        end
      end
      default: begin
        empty_queue_model();
        r.status = ST_CLEARED;
      end
    endcase
    r.count = CNT_W'(live_count);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_request(logic [1:0] op, request_t rq, logic prio, logic npc,
                              logic idle);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.requester_id <= rq.id;
    req_if.from_anchor <= rq.src;
    req_if.to_anchor <= rq.dst;
    req_if.request_valid <= rq.vld;
    req_if.priority_request <= prio;
    req_if.head_owner_is_npc <= npc;
    req_if.head_owner_idle <= idle;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    replies_due.push_back(advance_queue_model(op, rq, prio, npc, idle));
  endtask

  task automatic check_field(string label, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want_v, got_v);
      error_count++;
    end
  endtask

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      stall_left = hold_off_cycles;
      hold_off_cycles = 0;
    end
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else if (!receiver_steady && $urandom_range(99) < 30) begin
      rsp_if.ready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result, status %0d count %0d", $time, rsp_if.status,
                 rsp_if.queue_count);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_if.status));
        check_field("out_requester_id", 32'(want.id), 32'(rsp_if.out_requester_id));
        check_field("out_from_anchor", 32'(want.src), 32'(rsp_if.out_from_anchor));
        check_field("out_to_anchor", 32'(want.dst), 32'(rsp_if.out_to_anchor));
        check_field("out_request_valid", 32'(want.vld), 32'(rsp_if.out_request_valid));
        check_field("queue_count", 32'(want.count), 32'(rsp_if.queue_count));
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("[coalescing_request_queue] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(OP_DEQ, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_CLR, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_ENQ, '{16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, 1'b0, 1'b0);
    // same id as the head: head may be in service, so a second entry is taken
    send_request(OP_ENQ, '{16'h0000, 16'h1111, 16'h2222, 1'b1}, 1'b0, 1'b0, 1'b0);
    send_request(OP_ENQ, '{16'hffff, 16'hffff, 16'hffff, 1'b1}, 1'b1, 1'b1, 1'b1);
    // head still matches first even though a later entry has this id
    send_request(OP_ENQ, '{16'h0000, 16'h3333, 16'h4444, 1'b0}, 1'b0, 1'b0, 1'b0);
    send_request(OP_ENQ, '{16'hffff, 16'h8001, 16'h7ffe, 1'b0}, 1'b0, 1'b0, 1'b0);
    send_request(OP_ENQ, '{16'h1234, 16'habcd, 16'h5678, 1'b1}, 1'b1, 1'b0, 1'b0);
    send_request(OP_DEQ, '1, 1'b1, 1'b1, 1'b0);
    send_request(OP_DEQ, '0, 1'b0, 1'b0, 1'b1);
    send_request(OP_DEQ, '0, 1'b0, 1'b1, 1'b1);
    send_request(OP_DEQ, '0, 1'b0, 1'b0, 1'b0);
    // priority with a single entry goes to the tail
    send_request(OP_ENQ, '{16'ha5a5, 16'h5a5a, 16'ha5a5, 1'b1}, 1'b1, 1'b0, 1'b0);
    send_request(OP_DEQ, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_DEQ, '0, 1'b0, 1'b1, 1'b0);
    send_request(OP_DEQ, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_ENQ, '{16'h5a5a, 16'h0f0f, 16'hf0f0, 1'b1}, 1'b0, 1'b0, 1'b0);
    send_request(OP_RSVD, '1, 1'b1, 1'b1, 1'b1);
    send_request(OP_DEQ, '0, 1'b0, 1'b0, 1'b0);
  endtask

  // fills the queue past full while the result side is held off
  task automatic test_full_under_backpressure();
    logic [15:0] base;
    request_t rq;
    base = 16'($urandom);
    sender_steady = 1'b1;
    send_request(OP_CLR, '0, 1'b0, 1'b0, 1'b0);
    hold_off_cycles = 400;
    for (int i = 0; i <= DEPTH + 1; i++) begin
      rq.id = base + 16'(i * 7);
      rq.src = 16'($urandom);
      rq.dst = 16'($urandom);
      rq.vld = 1'($urandom_range(1));
      send_request(OP_ENQ, rq, 1'($urandom_range(1)), 1'b0, 1'b0);
    end
    rq.id = base;
    send_request(OP_ENQ, rq, 1'b0, 1'b0, 1'b0);
    rq.id = base + 16'd14;
    rq.src = 16'($urandom);
    send_request(OP_ENQ, rq, 1'b1, 1'b0, 1'b0);
    repeat (DEPTH + 1) begin
      send_request(OP_DEQ, '0, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    sender_steady = 1'b0;
  endtask

  task automatic test_random_traffic(int target);
    int sent;
    int phase_len;
    int enq_pct;
    int pool_n;
    int roll;
    logic [15:0] id_pool [40];
    request_t rq;
    sent = 0;
    while (sent < target) begin
      phase_len = $urandom_range(60, 15);
      case ($urandom_range(2))
        0: enq_pct = 82;
        1: enq_pct = 55;
        default: enq_pct = 30;
      endcase
      // small pools make matches at the head and overwrites common
      pool_n = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 6);
      for (int i = 0; i < pool_n; i++) id_pool[i] = 16'($urandom);
      sender_steady = ($urandom_range(4) == 0);
      receiver_steady = ($urandom_range(4) == 0);
      repeat (phase_len) begin
        rq.id = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(pool_n - 1)];
        rq.src = 16'($urandom);
        rq.dst = 16'($urandom);
        rq.vld = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < 2) begin
          send_request($urandom_range(1) ? OP_RSVD : OP_CLR, rq, 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
        end else if (roll < enq_pct) begin
          send_request(OP_ENQ, rq, $urandom_range(9) < 3, 1'($urandom_range(1)),
                       1'($urandom_range(1)));
        end else begin
          send_request(OP_DEQ, rq, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
        end
        sent++;
      end
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.opcode = OP_ENQ;
    req_if.requester_id = '0;
    req_if.from_anchor = '0;
    req_if.to_anchor = '0;
    req_if.request_valid = 1'b0;
    req_if.priority_request = 1'b0;
    req_if.head_owner_is_npc = 1'b0;
    req_if.head_owner_idle = 1'b0;
    empty_queue_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_under_backpressure();
    test_random_traffic(760);

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[coalescing_request_queue] OK");
    end else begin
      $display("[coalescing_request_queue] ERROR");
    end
    $finish;
  end

endmodule
